### hdl/cumulative_trapezoid_integrator_assert.svh
// Assertion macros for the cumulative trapezoid integrator checkers.
// Used by the port checker; needs nothing else.
`ifndef CUMULATIVE_TRAPEZOID_INTEGRATOR_ASSERT_SVH
`define CUMULATIVE_TRAPEZOID_INTEGRATOR_ASSERT_SVH

// consequent in the same cycle as the antecedent
`define CTI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define CTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cti_pkg.sv
// Shared widths, codes and control structs of the trapezoid integrator.
// No dependencies; every file but the assertion macro header refers to it by scoped names.
package cti_pkg;

  // field widths of the channels
  localparam int SampleFieldWidth = 16;
  localparam int SigmaFieldWidth  = 12;
  localparam int IntWidth         = 64;
  localparam int ErrWidth         = 32;
  localparam int ModeWidth        = 2;

  // widths actually used inside the fields
  localparam int SampleWidth = 16;
  localparam int SigmaWidth  = 12;

  // derived datapath widths
  localparam int AbsWidth    = SampleWidth + 1;
  localparam int SqWidth     = 2 * AbsWidth;
  localparam int SigSqWidth  = 2 * SigmaWidth + 1;
  localparam int TermWidth   = SqWidth + SigSqWidth;
  localparam int MulSteps    = (AbsWidth > SigmaWidth) ? AbsWidth : SigmaWidth;
  localparam int TermSteps   = (MulSteps > SigSqWidth) ? MulSteps : SigSqWidth;
  localparam int TermCntWidth = $clog2(TermSteps);
  localparam int RootSteps   = ErrWidth;
  localparam int RootCntWidth = $clog2(RootSteps);
  localparam int RemWidth    = ErrWidth + 3;

  // error mode codes
  localparam logic [ModeWidth-1:0] ModeNone = 2'd0;
  localparam int ModeXBit = 0;
  localparam int ModeYBit = 1;

  typedef struct packed {
    logic                  start;
    logic [AbsWidth-1:0]   ady;
    logic [AbsWidth-1:0]   adx;
    logic [SigmaWidth-1:0] sx;
    logic [SigmaWidth-1:0] psx;
    logic [SigmaWidth-1:0] sy;
    logic [SigmaWidth-1:0] psy;
  } terms_req_t;

  typedef struct packed {
    logic                 done;
    logic [SqWidth-1:0]   mag_xy;
    logic [TermWidth-1:0] term_x;
    logic [TermWidth-1:0] term_y;
  } terms_rsp_t;

  typedef struct packed {
    logic                start;
    logic [IntWidth-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic                done;
    logic [ErrWidth-1:0] root;
  } root_rsp_t;

endpackage

### hdl/cti_in_if.sv
// Sample request channel: valid, ready and one (x, y) sample with sigmas.
// Depends on cti_pkg for field widths.
interface cti_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  start_of_set;
  logic signed [cti_pkg::SampleFieldWidth-1:0] sample_x;
  logic signed [cti_pkg::SampleFieldWidth-1:0] sample_y;
  logic [cti_pkg::SigmaFieldWidth-1:0]   sigma_x;
  logic [cti_pkg::SigmaFieldWidth-1:0]   sigma_y;

  modport source (output valid, start_of_set, sample_x, sample_y, sigma_x, sigma_y,
                  input ready);
  modport sink   (input valid, start_of_set, sample_x, sample_y, sigma_x, sigma_y,
                  output ready);
endinterface

### hdl/cti_out_if.sv
// Result channel: valid, ready, running integral, error and saturation flag.
// Depends on cti_pkg for field widths.
interface cti_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cti_pkg::IntWidth-1:0] integral_twice;
  logic [cti_pkg::ErrWidth-1:0]        error_twice;
  logic                                saturated;

  modport source (output valid, integral_twice, error_twice, saturated, input ready);
  modport sink   (input valid, integral_twice, error_twice, saturated, output ready);
endinterface

### hdl/cumulative_trapezoid_integrator.sv
// Cumulative trapezoid integrator with propagated error, top level.
// Depends on cti_pkg, cti_in_if, cti_out_if, cti_terms and cti_isqrt.
//
// Usage:
//   in_req_i carries one sample per request: start_of_set, sample_x, sample_y,
//   sigma_x and sigma_y. out_res_o returns one result per request: twice the
//   running integral, the floored square root of the variance sum and the
//   saturation flag. cfg_we_i/cfg_wdata_i write error_mode; write it only
//   while no request is in flight.
//   A start-of-set request clears the sums; its zero result passes through
//   S_PUSH into the output register. Any other request runs in order through
//   the bit-serial products, then the variance terms one sigma-sum bit per
//   cycle, then the square root two radicand bits per cycle, then S_PUSH.
//   ready is high only while no request is being worked on, so the next request
//   is taken at the earliest in the cycle in which the result turns valid.
//   The result sits in an output register; a stalled receiver holds it there,
//   while the next request is already accepted and worked on. Only the handover
//   of the following result waits for the register to free.
//   Reset clears the mode, the sums, the previous sample and all handshakes.
module cumulative_trapezoid_integrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cti_pkg::ModeWidth-1:0]     cfg_wdata_i,
  cti_in_if.sink                            in_req_i,
  cti_out_if.source                         out_res_o
);

  typedef enum logic [1:0] {S_IDLE, S_TERMS, S_ROOT, S_PUSH} state_e;

  state_e                              state_q;
  logic [cti_pkg::ModeWidth-1:0]       mode_q;
  logic signed [cti_pkg::SampleWidth-1:0] prev_x_q, prev_y_q;
  logic [cti_pkg::SigmaWidth-1:0]      prev_sx_q, prev_sy_q;
  logic [cti_pkg::IntWidth-1:0]        integral_q;
  logic [cti_pkg::IntWidth-1:0]        variance_q;
  logic                                sat_q;
  logic                                neg_q;
  logic [cti_pkg::ErrWidth-1:0]        err_q;

  logic                                out_valid_q;
  logic [cti_pkg::IntWidth-1:0]        out_int_q;
  logic [cti_pkg::ErrWidth-1:0]        out_err_q;
  logic                                out_sat_q;

  cti_pkg::terms_req_t terms_req;
  cti_pkg::terms_rsp_t terms_rsp;
  cti_pkg::root_req_t  root_req;
  cti_pkg::root_rsp_t  root_rsp;

  logic                                   in_acc;
  logic signed [cti_pkg::SampleWidth-1:0] x, y;
  logic signed [cti_pkg::AbsWidth-1:0]    dy, dx;
  logic [cti_pkg::AbsWidth-1:0]           ady, adx;
  logic [cti_pkg::SigmaWidth-1:0]         sx, sy;

  logic [cti_pkg::IntWidth-1:0]   mag64, addend, int_sum, int_d;
  logic                           int_ovf;
  logic [cti_pkg::IntWidth+1:0]   var_sum;
  logic [cti_pkg::IntWidth-1:0]   var_d;
  logic                           var_ovf;
  logic                           finish_terms;

  assign in_req_i.ready = (state_q == S_IDLE);
  assign in_acc         = in_req_i.valid && (state_q == S_IDLE);

  assign x  = in_req_i.sample_x[cti_pkg::SampleWidth-1:0];
  assign y  = in_req_i.sample_y[cti_pkg::SampleWidth-1:0];
  assign sx = in_req_i.sigma_x[cti_pkg::SigmaWidth-1:0];
  assign sy = in_req_i.sigma_y[cti_pkg::SigmaWidth-1:0];

  assign dy  = cti_pkg::AbsWidth'(y) + cti_pkg::AbsWidth'(prev_y_q);
  assign dx  = cti_pkg::AbsWidth'(x) - cti_pkg::AbsWidth'(prev_x_q);
  assign ady = dy[cti_pkg::AbsWidth-1] ? cti_pkg::AbsWidth'(-dy) : cti_pkg::AbsWidth'(dy);
  assign adx = dx[cti_pkg::AbsWidth-1] ? cti_pkg::AbsWidth'(-dx) : cti_pkg::AbsWidth'(dx);

  assign terms_req.start = in_acc && !in_req_i.start_of_set;
  assign terms_req.ady   = ady;
  assign terms_req.adx   = adx;
  assign terms_req.sx    = sx;
  assign terms_req.psx   = prev_sx_q;
  assign terms_req.sy    = sy;
  assign terms_req.psy   = prev_sy_q;

  cti_terms u_terms (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (terms_req),
    .rsp_o  (terms_rsp)
  );

  assign finish_terms = (state_q == S_TERMS) && terms_rsp.done;

  // saturating accumulation of both running sums
  always_comb begin
    mag64   = cti_pkg::IntWidth'(terms_rsp.mag_xy);
    addend  = neg_q ? (~mag64 + 1'b1) : mag64;
    int_sum = integral_q + addend;
    int_ovf = (integral_q[cti_pkg::IntWidth-1] == addend[cti_pkg::IntWidth-1]) &&
              (int_sum[cti_pkg::IntWidth-1] != integral_q[cti_pkg::IntWidth-1]);
    if (!int_ovf) begin
      int_d = int_sum;
    end else if (integral_q[cti_pkg::IntWidth-1]) begin
      int_d = {1'b1, {(cti_pkg::IntWidth-1){1'b0}}};
    end else begin
      int_d = {1'b0, {(cti_pkg::IntWidth-1){1'b1}}};
    end

    var_sum = (cti_pkg::IntWidth+2)'(variance_q)
            + (mode_q[cti_pkg::ModeXBit] ? (cti_pkg::IntWidth+2)'(terms_rsp.term_x) : '0)
            + (mode_q[cti_pkg::ModeYBit] ? (cti_pkg::IntWidth+2)'(terms_rsp.term_y) : '0);
    if (mode_q == cti_pkg::ModeNone) begin
      var_ovf = 1'b0;
      var_d   = '0;
    end else begin
      var_ovf = |var_sum[cti_pkg::IntWidth+1:cti_pkg::IntWidth];
      var_d   = var_ovf ? '1 : var_sum[cti_pkg::IntWidth-1:0];
    end
  end

  assign root_req.start    = finish_terms;
  assign root_req.radicand = var_d;

  cti_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= cti_pkg::ModeNone;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_sx_q   <= '0;
      prev_sy_q   <= '0;
      integral_q  <= '0;
      variance_q  <= '0;
      sat_q       <= 1'b0;
      neg_q       <= 1'b0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
      out_int_q   <= '0;
      out_err_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      // drop the result once the receiver has taken it
      if (out_valid_q && out_res_o.ready && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            prev_x_q  <= x;
            prev_y_q  <= y;
            prev_sx_q <= sx;
            prev_sy_q <= sy;
            neg_q     <= dy[cti_pkg::AbsWidth-1] ^ dx[cti_pkg::AbsWidth-1];
            if (in_req_i.start_of_set) begin
              integral_q <= '0;
              variance_q <= '0;
              sat_q      <= 1'b0;
              err_q      <= '0;
              state_q    <= S_PUSH;
            end else begin
              state_q <= S_TERMS;
            end
          end
        end
        S_TERMS: begin
          if (terms_rsp.done) begin
            integral_q <= int_d;
            variance_q <= var_d;
            sat_q      <= sat_q | int_ovf | var_ovf;
            state_q    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_rsp.done) begin
            err_q   <= root_rsp.root;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold until the output register is free
          if (!out_valid_q || out_res_o.ready) begin
            out_valid_q <= 1'b1;
            out_int_q   <= integral_q;
            out_err_q   <= err_q;
            out_sat_q   <= sat_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_res_o.valid          = out_valid_q;
  assign out_res_o.integral_twice = out_int_q;
  assign out_res_o.error_twice    = out_err_q;
  assign out_res_o.saturated      = out_sat_q;

endmodule

### hdl/cti_terms.sv
// Bit-serial product unit: |dy|*|dx|, the squares of |dy| and |dx|, the sigma
// sums and the two variance terms, one multiplier bit per cycle. Uses cti_pkg.
module cti_terms (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cti_pkg::terms_req_t req_i,
  output cti_pkg::terms_rsp_t rsp_o
);

  typedef enum logic [1:0] {T_IDLE, T_SQ, T_LOAD, T_TERM} tstate_e;

  tstate_e                           state_q;
  logic [cti_pkg::TermCntWidth-1:0]  cnt_q;
  logic                              done_q;

  // squares phase
  logic [cti_pkg::SqWidth-1:0]    mc_ady_q, mc_adx_q;
  logic [cti_pkg::AbsWidth-1:0]   mr_ady_q, mr_adx_q;
  logic [cti_pkg::SqWidth-1:0]    acc_xy_q, acc_yy_q, acc_xx_q;
  logic [cti_pkg::SigSqWidth-1:0] mc_sx_q, mc_psx_q, mc_sy_q, mc_psy_q;
  logic [cti_pkg::SigmaWidth-1:0] mr_sx_q, mr_psx_q, mr_sy_q, mr_psy_q;
  logic [cti_pkg::SigSqWidth-1:0] acc_sxs_q, acc_sys_q;
  // term phase
  logic [cti_pkg::TermWidth-1:0]  mc_t1_q, mc_t2_q, acc_t1_q, acc_t2_q;
  logic [cti_pkg::SigSqWidth-1:0] mr_t1_q, mr_t2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == T_TERM) &&
                (cnt_q == cti_pkg::TermCntWidth'(cti_pkg::SigSqWidth - 1));
      case (state_q)
        T_IDLE: begin
          if (req_i.start) begin
            state_q <= T_SQ;
            cnt_q   <= '0;
          end
        end
        T_SQ: begin
          if (cnt_q == cti_pkg::TermCntWidth'(cti_pkg::MulSteps - 1)) begin
            state_q <= T_LOAD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        T_LOAD: begin
          state_q <= T_TERM;
          cnt_q   <= '0;
        end
        T_TERM: begin
          if (cnt_q == cti_pkg::TermCntWidth'(cti_pkg::SigSqWidth - 1)) begin
            state_q <= T_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      T_IDLE: begin
        if (req_i.start) begin
          mc_ady_q  <= cti_pkg::SqWidth'(req_i.ady);
          mc_adx_q  <= cti_pkg::SqWidth'(req_i.adx);
          mr_ady_q  <= req_i.ady;
          mr_adx_q  <= req_i.adx;
          mc_sx_q   <= cti_pkg::SigSqWidth'(req_i.sx);
          mc_psx_q  <= cti_pkg::SigSqWidth'(req_i.psx);
          mc_sy_q   <= cti_pkg::SigSqWidth'(req_i.sy);
          mc_psy_q  <= cti_pkg::SigSqWidth'(req_i.psy);
          mr_sx_q   <= req_i.sx;
          mr_psx_q  <= req_i.psx;
          mr_sy_q   <= req_i.sy;
          mr_psy_q  <= req_i.psy;
          acc_xy_q  <= '0;
          acc_yy_q  <= '0;
          acc_xx_q  <= '0;
          acc_sxs_q <= '0;
          acc_sys_q <= '0;
        end
      end
      T_SQ: begin
        acc_xy_q  <= acc_xy_q + (mr_adx_q[0] ? mc_ady_q : '0);
        acc_yy_q  <= acc_yy_q + (mr_ady_q[0] ? mc_ady_q : '0);
        acc_xx_q  <= acc_xx_q + (mr_adx_q[0] ? mc_adx_q : '0);
        acc_sxs_q <= acc_sxs_q + (mr_sx_q[0] ? mc_sx_q : '0)
                     + (mr_psx_q[0] ? mc_psx_q : '0);
        acc_sys_q <= acc_sys_q + (mr_sy_q[0] ? mc_sy_q : '0)
                     + (mr_psy_q[0] ? mc_psy_q : '0);
        mc_ady_q  <= mc_ady_q << 1;
        mc_adx_q  <= mc_adx_q << 1;
        mc_sx_q   <= mc_sx_q << 1;
        mc_psx_q  <= mc_psx_q << 1;
        mc_sy_q   <= mc_sy_q << 1;
        mc_psy_q  <= mc_psy_q << 1;
        mr_ady_q  <= mr_ady_q >> 1;
        mr_adx_q  <= mr_adx_q >> 1;
        mr_sx_q   <= mr_sx_q >> 1;
        mr_psx_q  <= mr_psx_q >> 1;
        mr_sy_q   <= mr_sy_q >> 1;
        mr_psy_q  <= mr_psy_q >> 1;
      end
      T_LOAD: begin
        // dy^2 pairs with the x sigmas, dx^2 with the y sigmas
        mc_t1_q  <= cti_pkg::TermWidth'(acc_yy_q);
        mr_t1_q  <= acc_sxs_q;
        mc_t2_q  <= cti_pkg::TermWidth'(acc_xx_q);
        mr_t2_q  <= acc_sys_q;
        acc_t1_q <= '0;
        acc_t2_q <= '0;
      end
      T_TERM: begin
        acc_t1_q <= acc_t1_q + (mr_t1_q[0] ? mc_t1_q : '0);
        acc_t2_q <= acc_t2_q + (mr_t2_q[0] ? mc_t2_q : '0);
        mc_t1_q  <= mc_t1_q << 1;
        mc_t2_q  <= mc_t2_q << 1;
        mr_t1_q  <= mr_t1_q >> 1;
        mr_t2_q  <= mr_t2_q >> 1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.mag_xy = acc_xy_q;
  assign rsp_o.term_x = acc_t1_q;
  assign rsp_o.term_y = acc_t2_q;

endmodule

### hdl/cti_isqrt.sv
// Digit-serial floor square root: two radicand bits per cycle, one root bit out.
// Uses cti_pkg for widths and the request/response structs.
module cti_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cti_pkg::root_req_t req_i,
  output cti_pkg::root_rsp_t rsp_o
);

  typedef enum logic {R_IDLE, R_RUN} rstate_e;

  rstate_e                          state_q;
  logic [cti_pkg::RootCntWidth-1:0] cnt_q;
  logic                             done_q;

  logic [cti_pkg::IntWidth-1:0] rad_q;
  logic [cti_pkg::RemWidth-1:0] rem_q;
  logic [cti_pkg::ErrWidth-1:0] root_q;

  logic [cti_pkg::RemWidth-1:0] rem_shift;
  logic [cti_pkg::RemWidth-1:0] trial;
  logic                         fits;

  // bring down the next digit and try root*4 + 1
  assign rem_shift = {rem_q[cti_pkg::RemWidth-3:0], rad_q[cti_pkg::IntWidth-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == R_RUN) &&
                (cnt_q == cti_pkg::RootCntWidth'(cti_pkg::RootSteps - 1));
      case (state_q)
        R_IDLE: begin
          if (req_i.start) begin
            state_q <= R_RUN;
            cnt_q   <= '0;
          end
        end
        R_RUN: begin
          if (cnt_q == cti_pkg::RootCntWidth'(cti_pkg::RootSteps - 1)) begin
            state_q <= R_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == R_IDLE) begin
      if (req_i.start) begin
        rad_q  <= req_i.radicand;
        rem_q  <= '0;
        root_q <= '0;
      end
    end else begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? (rem_shift - trial) : rem_shift;
      root_q <= {root_q[cti_pkg::ErrWidth-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

### hdl/cti_port_checker.sv
// Port-level checks of the trapezoid integrator, bound to its top level.
// Depends on cti_pkg and the assertion macro header.
`include "cumulative_trapezoid_integrator_assert.svh"

module cti_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [cti_pkg::IntWidth-1:0]  out_integral_i,
  input logic [cti_pkg::ErrWidth-1:0]  out_error_i
);

  logic in_acc, out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `CTI_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_i, "result dropped while stalled")
  `CTI_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_stall, $stable(out_integral_i) && $stable(out_error_i), "result changed while stalled")
  `CTI_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_acc, !in_ready_i, "request taken while one is in flight")
  `CTI_ASSERT_SAME(a_ready_on_result, clk_i, rst_ni, $rose(out_valid_i), in_ready_i, "new result without returning to idle")

endmodule

bind cumulative_trapezoid_integrator cti_port_checker u_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_req_i.valid),
  .in_ready_i     (in_req_i.ready),
  .out_valid_i    (out_res_o.valid),
  .out_ready_i    (out_res_o.ready),
  .out_integral_i (out_res_o.integral_twice),
  .out_error_i    (out_res_o.error_twice)
);

### bench/cti_result_monitor.sv
// Result monitor for the trapezoid integrator: watches the mode write port and
// both channels, predicts every result and compares it field by field.
// Depends on cti_pkg, cti_in_if and cti_out_if.
module cti_result_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cti_pkg::ModeWidth-1:0] cfg_wdata_i,
  cti_in_if                             req_i,
  cti_out_if                            res_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [cti_pkg::IntWidth-1:0] integral_twice;
    logic [cti_pkg::ErrWidth-1:0]        error_twice;
    logic                                saturated;
  } trap_result_t;

  trap_result_t                  expected_results[$];
  logic [cti_pkg::ModeWidth-1:0] mode_shadow;
  longint                        prev_x;
  longint                        prev_y;
  longint unsigned               prev_sx;
  longint unsigned               prev_sy;
  logic signed [63:0]            integral_acc;
  logic [63:0]                   variance_acc;
  logic                          sat_seen;
  int                            mismatches;

  // floor square root, one result bit per trial from the top down
  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic add_variance(logic [63:0] term);
    logic [64:0] wide;
    wide = {1'b0, variance_acc} + {1'b0, term};
    variance_acc = wide[64] ? '1 : wide[63:0];
    return wide[64];
  endfunction

  function automatic trap_result_t integrate_sample(
    logic start, logic signed [15:0] x, logic signed [15:0] y, logic [11:0] sx, logic [11:0] sy
  );
    longint             dy;
    longint             dx;
    longint unsigned    ady;
    longint unsigned    adx;
    longint unsigned    sum_sx;
    longint unsigned    sum_sy;
    logic signed [63:0] product;
    logic signed [63:0] total;
    logic               overflow;
    trap_result_t       r;
    overflow = 1'b0;
    if (start) begin
      integral_acc = '0;
      variance_acc = '0;
      sat_seen     = 1'b0;
    end else begin
      dy  = longint'(y) + prev_y;
      dx  = longint'(x) - prev_x;
      ady = (dy < 0) ? -dy : dy;
      adx = (dx < 0) ? -dx : dx;
      product = dy * dx;
      total   = integral_acc + product;
      // clamp towards the side the sum ran off
      if (integral_acc[63] == product[63] && total[63] != product[63]) begin
        overflow = 1'b1;
        total    = integral_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      integral_acc = total;
      if (mode_shadow == cti_pkg::ModeNone) begin
        variance_acc = '0;
      end else begin
        sum_sx = prev_sx * prev_sx + 64'(sx) * 64'(sx);
        sum_sy = prev_sy * prev_sy + 64'(sy) * 64'(sy);
        if (mode_shadow[cti_pkg::ModeXBit]) overflow |= add_variance(ady * ady * sum_sx);
        if (mode_shadow[cti_pkg::ModeYBit]) overflow |= add_variance(adx * adx * sum_sy);
      end
      if (overflow) sat_seen = 1'b1;
    end
    prev_x  = x;
    prev_y  = y;
    prev_sx = sx;
    prev_sy = sy;
    r.integral_twice = integral_acc;
    r.error_twice    = floor_root(variance_acc);
    r.saturated      = sat_seen;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trap_result_t got;
    trap_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      mode_shadow  = cti_pkg::ModeNone;
      prev_x       = 0;
      prev_y       = 0;
      prev_sx      = 0;
      prev_sy      = 0;
      integral_acc = '0;
      variance_acc = '0;
      sat_seen     = 1'b0;
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) mode_shadow = cfg_wdata_i;
      if (res_i.valid && res_i.ready) begin
        got.integral_twice = res_i.integral_twice;
        got.error_twice    = res_i.error_twice;
        got.saturated      = res_i.saturated;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unrequested result: integral_twice %0d error_twice %0d saturated %0b",
                   $time, got.integral_twice, got.error_twice, got.saturated);
        end else begin
          want = expected_results.pop_front();
          if (got.integral_twice !== want.integral_twice) begin
            mismatches++;
            $display("%0t: integral_twice expected %0d actual %0d",
                     $time, want.integral_twice, got.integral_twice);
          end
          if (got.error_twice !== want.error_twice) begin
            mismatches++;
            $display("%0t: error_twice expected %0d actual %0d",
                     $time, want.error_twice, got.error_twice);
          end
          if (got.saturated !== want.saturated) begin
            mismatches++;
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.saturated, got.saturated);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(integrate_sample(req_i.start_of_set, req_i.sample_x,
                                                    req_i.sample_y, req_i.sigma_x,
                                                    req_i.sigma_y));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

### bench/tb_top.sv
// Regression top for the trapezoid integrator: clock, reset, mode writes,
// sample requests and result back-pressure; the verdict comes from
// cti_result_monitor. Depends on cti_pkg, both channel interfaces and the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles   = 8;
  localparam int RandomItems   = 2000;
  localparam int CycleLimit    = 2_000_000;
  localparam int HoldOffCycles = 800;
  localparam int SettleCycles  = 120;
  localparam int SaturateSteps = 72;

  localparam logic [cti_pkg::ModeWidth-1:0] ModeXOnly =
    cti_pkg::ModeWidth'(1 << cti_pkg::ModeXBit);
  localparam logic [cti_pkg::ModeWidth-1:0] ModeYOnly =
    cti_pkg::ModeWidth'(1 << cti_pkg::ModeYBit);
  localparam logic [cti_pkg::ModeWidth-1:0] ModeBoth  = ModeXOnly | ModeYOnly;

  typedef struct packed {
    logic                                  start;
    logic [cti_pkg::SampleFieldWidth-1:0] x;
    logic [cti_pkg::SampleFieldWidth-1:0] y;
    logic [cti_pkg::SigmaFieldWidth-1:0]  sx;
    logic [cti_pkg::SigmaFieldWidth-1:0]  sy;
  } sample_req_t;

  typedef enum logic [1:0] {ReadyAlways, ReadyCoin, ReadySparse, ReadyPeriodic} ready_style_e;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cti_pkg::ModeWidth-1:0] cfg_wdata;
  logic                          hold_off_req;
  int                            fail_count;
  int                            results_pending;
  int                            cycle_count = 0;
  int                            burst_left = 0;

  cti_in_if  in_req ();
  cti_out_if out_res ();

  cumulative_trapezoid_integrator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_req_i    (in_req),
    .out_res_o   (out_res)
  );

  cti_result_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (in_req),
    .res_i        (out_res),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold a request on the channel until the block takes it
  task automatic send_request(sample_req_t r);
    in_req.valid        <= 1'b1;
    in_req.start_of_set <= r.start;
    in_req.sample_x     <= r.x;
    in_req.sample_y     <= r.y;
    in_req.sigma_x      <= r.sx;
    in_req.sigma_y      <= r.sy;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
  endtask

  task automatic pause_requests(int cycles);
    in_req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic offer(sample_req_t r);
    int gap;
    send_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
      pause_requests(gap);
    end
  endtask

  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // mode is only written with nothing in flight
  task automatic set_error_mode(logic [cti_pkg::ModeWidth-1:0] mode);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] random_value(logic heavy);
    case ($urandom_range(0, heavy ? 1 : 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] random_sigma(logic heavy);
    if (heavy) return 12'hfff;
    case ($urandom_range(0, 3))
      0:       return 12'h000;
      1:       return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic sample_req_t random_sample(logic start, logic heavy);
    sample_req_t r;
    r.start = start;
    r.x     = random_value(heavy);
    r.y     = random_value(heavy);
    r.sx    = random_sigma(heavy);
    r.sy    = random_sigma(heavy);
    return r;
  endfunction

  // result back-pressure: changing ready patterns plus one long hold-off
  initial begin
    ready_style_e style;
    int           style_left;
    int           period;
    logic         hold_off_done;
    out_res.ready <= 1'b0;
    style         = ReadyAlways;
    style_left    = 0;
    period        = 2;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_res.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk);
      end else begin
        if (style_left == 0) begin
          style      = ready_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(50, 400);
          period     = $urandom_range(2, 9);
        end
        style_left--;
        case (style)
          ReadyAlways: out_res.ready <= 1'b1;
          ReadyCoin:   out_res.ready <= 1'($urandom_range(0, 1));
          ReadySparse: out_res.ready <= ($urandom_range(0, 7) == 0);
          default:     out_res.ready <= (style_left % period) != 0;
        endcase
      end
    end
  end

  initial begin
    logic [cti_pkg::ModeWidth-1:0] mode_order[4];
    logic [cti_pkg::ModeWidth-1:0] mode;
    int                            phase_idx;
    int                            phase_len;
    int                            items_sent;
    int                            set_left;
    logic                          start_set;
    logic                          heavy_set;
    mode_order = '{cti_pkg::ModeNone, ModeYOnly, ModeXOnly, ModeBoth};
    rst_n = 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= cti_pkg::ModeNone;
    hold_off_req        <= 1'b0;
    in_req.valid        <= 1'b0;
    in_req.start_of_set <= 1'b0;
    in_req.sample_x     <= '0;
    in_req.sample_y     <= '0;
    in_req.sigma_x      <= '0;
    in_req.sigma_y      <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first samples lean on the cleared reset sample as predecessor
    set_error_mode(ModeBoth);
    offer('{1'b0, 16'h7fff, 16'h8000, 12'hfff, 12'hfff});
    offer('{1'b0, 16'h8000, 16'h8000, 12'hfff, 12'hfff});
    offer('{1'b0, 16'h7fff, 16'h7fff, 12'h000, 12'h000});
    offer('{1'b0, 16'h0000, 16'h0000, 12'haaa, 12'h555});
    offer('{1'b0, 16'hffff, 16'hffff, 12'h555, 12'haaa});
    offer('{1'b1, 16'h1234, 16'hfedc, 12'h0ab, 12'h7c1});
    offer('{1'b0, 16'h1234, 16'hfedc, 12'h001, 12'h001});
    offer('{1'b0, 16'h5555, 16'haaaa, 12'h800, 12'h7ff});
    offer('{1'b0, 16'haaaa, 16'h5555, 12'hfff, 12'h000});
    set_error_mode(ModeXOnly);
    offer('{1'b0, 16'h0001, 16'h0001, 12'h000, 12'hfff});
    offer('{1'b0, 16'h8000, 16'h7fff, 12'hfff, 12'h000});
    offer('{1'b1, 16'h0000, 16'h0000, 12'h000, 12'h000});
    set_error_mode(ModeYOnly);
    offer('{1'b0, 16'h7fff, 16'h0000, 12'h000, 12'hfff});
    offer('{1'b0, 16'h8000, 16'hffff, 12'h123, 12'hfff});
    set_error_mode(cti_pkg::ModeNone);
    offer('{1'b0, 16'h0100, 16'h0200, 12'hfff, 12'hfff});
    offer('{1'b0, 16'h8000, 16'h8000, 12'hfff, 12'hfff});
    offer('{1'b1, 16'h7fff, 16'h7fff, 12'hfff, 12'hfff});
    offer('{1'b0, 16'h0000, 16'h8000, 12'h000, 12'h000});

    // drive the variance sum into saturation and keep going past it
    set_error_mode(ModeBoth);
    offer('{1'b1, 16'h8000, 16'h8000, 12'hfff, 12'hfff});
    for (int i = 0; i < SaturateSteps; i++) begin
      offer('{1'b0, (i % 2) ? 16'h8000 : 16'h7fff, 16'h8000, 12'hfff, 12'hfff});
    end

    // fill the block while results are held back
    set_error_mode(ModeXOnly);
    hold_off_req <= 1'b1;
    for (int i = 0; i < 10; i++) send_request(random_sample(i == 0, 1'b0));

    items_sent = 0;
    set_left   = 0;
    phase_idx  = 0;
    heavy_set  = 1'b0;
    while (items_sent < RandomItems) begin
      mode = (phase_idx < 4) ? mode_order[phase_idx] : 2'($urandom_range(0, 3));
      set_error_mode(mode);
      phase_len = $urandom_range(100, 300);
      repeat (phase_len) begin
        start_set = 1'b0;
        if (set_left == 0) begin
          start_set = 1'b1;
          heavy_set = 1'b0;
          case ($urandom_range(0, 19))
            0: begin
              set_left  = $urandom_range(60, 140);
              heavy_set = 1'b1;
            end
            1, 2, 3: set_left = $urandom_range(13, 40);
            default: set_left = $urandom_range(1, 12);
          endcase
        end
        offer(random_sample(start_set, heavy_set));
        set_left--;
        items_sent++;
      end
      phase_idx++;
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### cumulative_trapezoid_integrator.f
+incdir+hdl
hdl/cti_pkg.sv
hdl/cti_in_if.sv
hdl/cti_out_if.sv
hdl/cti_terms.sv
hdl/cti_isqrt.sv
hdl/cumulative_trapezoid_integrator.sv
hdl/cti_port_checker.sv
bench/cti_result_monitor.sv
bench/tb_top.sv
